/* design/tot_pkg.sv */
// ----------------------------------------------------------------------------
// tot_pkg
// Shared widths and register indexes for the tiled offset to index unit.
// ----------------------------------------------------------------------------
package tot_pkg;

  localparam int CFG_W    = 25;
  localparam int COLS_W   = 25;
  localparam int ROWS_W   = 21;
  localparam int TILE_W   = 17;
  localparam int OFS_W    = 44;
  localparam int COL_O_W  = 24;
  localparam int ROW_O_W  = 20;
  localparam int CIDX_W   = 2;

  localparam logic [CIDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TILE_COLUMNS = 2'd2;
  localparam logic [CIDX_W-1:0] REG_TILE_ROWS    = 2'd3;

endpackage

/* design/tiled_offset_to_index_unit.sv */
// ----------------------------------------------------------------------------
// tiled_offset_to_index_unit
// Maps a linear offset into a tiled matrix to its row and column index.
// ----------------------------------------------------------------------------
// One word is accepted per cycle and one result word leaves per cycle while
// no result is stalled. The pipeline is one input stage, three bit-per-stage
// divider pipelines (21, 25 and 17 stages for tile row, tile column and row
// within tile), five stages of tile size and margin clipping products between
// them, and the output register. The whole pipeline holds while a result is
// stalled. Sizes derived from the registers are registered in the cycle after
// a write, and the range check reads them on the cycle after the input
// stage, so a word may follow a register write on the very next cycle.
module tiled_offset_to_index_unit
  import tot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CIDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OFS_W-1:0]     in_offset,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COL_O_W-1:0]   out_column_index,
  output logic [ROW_O_W-1:0]   out_row_index,
  output logic                 out_out_of_range
);

  localparam int BLK_W  = COLS_W + TILE_W;   // cols * tile_rows
  localparam int AREA_W = COLS_W + ROWS_W;
  localparam int PT_W   = 2 * TILE_W;        // tile_columns * rows_here
  localparam int RB_W   = ROWS_W + TILE_W;
  localparam int CB_W   = COLS_W + TILE_W;
  localparam int TR_Q   = ROWS_W;
  localparam int TC_Q   = COLS_W;
  localparam int RI_Q   = TILE_W;

  logic [COLS_W-1:0] cols_r;
  logic [ROWS_W-1:0] rows_r;
  logic [TILE_W-1:0] tc_r, tr_r;
  logic [TILE_W-1:0] tce_r, tre_r;
  logic [BLK_W-1:0]  blk_r;
  logic [AREA_W-1:0] area_r;
  logic              empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_W'(1);
      rows_r <= ROWS_W'(1);
      tc_r   <= TILE_W'(1);
      tr_r   <= TILE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_COUNT: cols_r <= cfg_data[COLS_W-1:0];
        REG_ROW_COUNT:    rows_r <= cfg_data[ROWS_W-1:0];
        REG_TILE_COLUMNS: tc_r   <= cfg_data[TILE_W-1:0];
        REG_TILE_ROWS:    tr_r   <= cfg_data[TILE_W-1:0];
        default: ;
      endcase
    end
  end

  // derived sizes, zero tile size counts as one
  always_ff @(posedge clk) begin
    tce_r   <= (tc_r == '0) ? TILE_W'(1) : tc_r;
    tre_r   <= (tr_r == '0) ? TILE_W'(1) : tr_r;
    blk_r   <= BLK_W'(cols_r) * BLK_W'((tr_r == '0) ? TILE_W'(1) : tr_r);
    area_r  <= AREA_W'(cols_r) * AREA_W'(rows_r);
    empty_r <= (cols_r == '0) || (rows_r == '0);
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // input stage, range check taken at its output
  logic             s0_vld_r;
  logic [OFS_W-1:0] s0_x_r;
  logic             s0_oor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x_r <= in_offset;
    end
  end

  assign s0_oor = empty_r || (AREA_W'(s0_x_r) >= area_r);

  // tile row
  logic             d1_vld;
  logic [TR_Q-1:0]  d1_quo;
  logic [BLK_W-1:0] d1_rem;
  logic             d1_oor;

  tot_div_pipe #(.NW(OFS_W), .DW(BLK_W), .QW(TR_Q), .SW(1)) u_div_row (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s0_vld_r), .in_num(s0_x_r), .in_den(blk_r), .in_side(s0_oor),
    .out_valid(d1_vld), .out_quo(d1_quo), .out_rem(d1_rem), .out_side(d1_oor)
  );

  // row base, rows in this tile row, words per tile
  logic             a_vld_r, b_vld_r, c_vld_r;
  logic             a_oor_r, b_oor_r, c_oor_r;
  logic [BLK_W-1:0] a_x_r, b_x_r, c_x_r;
  logic [RB_W-1:0]  a_rb_r;
  logic [ROW_O_W-1:0] b_rb_r, c_rb_r;
  logic [TILE_W-1:0]  b_rh_r;
  logic [PT_W-1:0]    c_pt_r;
  logic [RB_W-1:0]    rows_left;
  logic [TILE_W-1:0]  rows_here;

  always_comb begin
    rows_left = RB_W'(rows_r) - a_rb_r;
    if (rows_left < RB_W'(tre_r)) begin
      rows_here = TILE_W'(rows_left);
    end else begin
      rows_here = tre_r;
    end
    if (rows_here == '0) begin
      rows_here = TILE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= d1_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_oor_r <= d1_oor;
      a_x_r   <= d1_rem;
      a_rb_r  <= RB_W'(d1_quo) * RB_W'(tre_r);
      b_oor_r <= a_oor_r;
      b_x_r   <= a_x_r;
      b_rb_r  <= a_rb_r[ROW_O_W-1:0];
      b_rh_r  <= rows_here;
      c_oor_r <= b_oor_r;
      c_x_r   <= b_x_r;
      c_rb_r  <= b_rb_r;
      c_pt_r  <= PT_W'(tce_r) * PT_W'(b_rh_r);
    end
  end

  // tile column
  localparam int S2_W = 1 + ROW_O_W;
  logic            d2_vld;
  logic [TC_Q-1:0] d2_quo;
  logic [PT_W-1:0] d2_rem;
  logic [S2_W-1:0] d2_side;

  tot_div_pipe #(.NW(BLK_W), .DW(PT_W), .QW(TC_Q), .SW(S2_W)) u_div_col (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(c_vld_r), .in_num(c_x_r), .in_den(c_pt_r), .in_side({c_oor_r, c_rb_r}),
    .out_valid(d2_vld), .out_quo(d2_quo), .out_rem(d2_rem), .out_side(d2_side)
  );

  // column base and clipped tile width
  logic              d_vld_r, e_vld_r;
  logic [S2_W-1:0]   d_side_r, e_side_r;
  logic [PT_W-1:0]   d_x_r, e_x_r;
  logic [CB_W-1:0]   d_cb_r;
  logic [COL_O_W-1:0] e_cb_r;
  logic [TILE_W-1:0]  e_ch_r;
  logic [CB_W-1:0]    cols_left;
  logic [TILE_W-1:0]  cols_here;

  always_comb begin
    if (d_cb_r < CB_W'(cols_r)) begin
      cols_left = CB_W'(cols_r) - d_cb_r;
    end else begin
      cols_left = CB_W'(1);
    end
    if (cols_left < CB_W'(tce_r)) begin
      cols_here = TILE_W'(cols_left);
    end else begin
      cols_here = tce_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= d2_vld;
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side_r <= d2_side;
      d_x_r    <= d2_rem;
      d_cb_r   <= CB_W'(d2_quo) * CB_W'(tce_r);
      e_side_r <= d_side_r;
      e_x_r    <= d_x_r;
      e_cb_r   <= d_cb_r[COL_O_W-1:0];
      e_ch_r   <= cols_here;
    end
  end

  // row and column within the tile
  localparam int S3_W = S2_W + COL_O_W;
  logic              d3_vld;
  logic [RI_Q-1:0]   d3_quo;
  logic [TILE_W-1:0] d3_rem;
  logic [S3_W-1:0]   d3_side;

  tot_div_pipe #(.NW(PT_W), .DW(TILE_W), .QW(RI_Q), .SW(S3_W)) u_div_in (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(e_vld_r), .in_num(e_x_r), .in_den(e_ch_r), .in_side({e_side_r, e_cb_r}),
    .out_valid(d3_vld), .out_quo(d3_quo), .out_rem(d3_rem), .out_side(d3_side)
  );

  // output word
  logic               o_vld_r;
  logic [COL_O_W-1:0] o_col_r;
  logic [ROW_O_W-1:0] o_row_r;
  logic               o_oor_r;
  logic               f_oor;
  logic [ROW_O_W-1:0] f_rb;
  logic [COL_O_W-1:0] f_cb;

  assign f_oor = d3_side[S3_W-1];
  assign f_rb  = d3_side[S3_W-2:COL_O_W];
  assign f_cb  = d3_side[COL_O_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_oor_r <= f_oor;
      if (f_oor) begin
        o_col_r <= '0;
        o_row_r <= '0;
      end else begin
        o_col_r <= f_cb + COL_O_W'(d3_rem);
        o_row_r <= f_rb + ROW_O_W'(d3_quo);
      end
    end
  end

  assign out_valid        = o_vld_r;
  assign out_column_index = o_col_r;
  assign out_row_index    = o_row_r;
  assign out_out_of_range = o_oor_r;

endmodule

/* design/tot_div_pipe.sv */
// ----------------------------------------------------------------------------
// tot_div_pipe
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband word that travels alongside.
// ----------------------------------------------------------------------------
module tot_div_pipe #(
  parameter int NW = 44,
  parameter int DW = 42,
  parameter int QW = 21,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [DW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  localparam int WW = NW + DW;

  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic [QW-1:0] vld_r;

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      logic [NW-1:0] src_rem;
      logic [DW-1:0] src_den;
      logic [QW-1:0] src_quo;
      logic [SW-1:0] src_side;
      logic          src_vld;
      logic [WW-1:0] dsh;
      logic [WW-1:0] rw;
      logic [NW-1:0] rem_nxt;
      logic [QW-1:0] quo_nxt;

      if (k == 0) begin : g_first
        assign src_rem  = in_num;
        assign src_den  = in_den;
        assign src_quo  = '0;
        assign src_side = in_side;
        assign src_vld  = in_valid;
      end else begin : g_next
        assign src_rem  = rem_r[k-1];
        assign src_den  = den_r[k-1];
        assign src_quo  = quo_r[k-1];
        assign src_side = side_r[k-1];
        assign src_vld  = vld_r[k-1];
      end

      // trial subtract of the divisor shifted to this quotient bit
      always_comb begin
        dsh = WW'(src_den) << (QW - 1 - k);
        rw  = WW'(src_rem);
        rem_nxt = src_rem;
        quo_nxt = src_quo;
        if (rw >= dsh) begin
          rem_nxt = NW'(rw - dsh);
          quo_nxt = src_quo | (QW'(1) << (QW - 1 - k));
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= src_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= rem_nxt;
          den_r[k]  <= src_den;
          quo_r[k]  <= quo_nxt;
          side_r[k] <= src_side;
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_rem   = DW'(rem_r[QW-1]);
  assign out_side  = side_r[QW-1];

endmodule
